@@ rtl/plfl_pkg.sv @@
// ----------------------------------------------------------------------------
// plfl_pkg
// Shared types and constants of the pool allocator with free list.
// ----------------------------------------------------------------------------
package plfl_pkg;

    localparam int FREE_SLOTS_DEF = 64;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_DEFRAG = 2'd2;

    localparam logic [1:0] POL_BUMP  = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_FIRST = 2'd2;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_LENGTH = 2'd2;
    localparam logic [1:0] CFG_POLICY = 2'd3;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
    } t_chunk;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_ROUND,
        S_DISPATCH,
        S_SCAN,
        S_TAKE_RD,
        S_TAKE_WR,
        S_SORT_NEXT,
        S_SORT_GETI,
        S_SORT_CMP,
        S_SORT_PUT,
        S_MERGE_NEXT,
        S_MERGE_GET,
        S_MERGE_END,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        ACT_BUMP,
        ACT_BEST,
        ACT_FIRST,
        ACT_DEFRAG,
        ACT_FAIL
    } t_act;

endpackage

@@ rtl/plfl_div.sv @@
// ----------------------------------------------------------------------------
// plfl_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plfl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvd, n_dvd;
    logic [31:0] r_dsr, n_dsr;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] sh;

    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        sh     = {r_rem[31:0], r_dvd[31]};
        if (i_start) begin
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[30:0], 1'b0};
            n_rem = (sh >= {1'b0, r_dsr}) ? sh - {1'b0, r_dsr} : sh;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[31:0];

endmodule

@@ rtl/plfl_mem.sv @@
// ----------------------------------------------------------------------------
// plfl_mem
// Free-list chunk store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module plfl_mem #(
    parameter int DEPTH = plfl_pkg::FREE_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  plfl_pkg::t_chunk  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output plfl_pkg::t_chunk  o_rdata
);

    plfl_pkg::t_chunk r_mem [DEPTH];
    plfl_pkg::t_chunk r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pool_allocator_free_list_unit.sv @@
// ----------------------------------------------------------------------------
// pool_allocator_free_list_unit
// Pool allocator with bump region and bounded free list.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) carries alloc, free or defragment
// requests; output channel (o_out_valid/i_out_ready) returns one item per
// request. One request is in work at a time; o_in_ready is high while idle.
// A free appends its chunk to the list in the decode state, then passes the
// result to the output register. Alloc rounds the size up to the alignment
// with the remainder unit, then tries a bump grant or a free-list scan that
// reads each entry through the single read port of the chunk memory; taking
// a chunk reads the last entry and writes it into the taken slot. Defragment
// is an insertion sort on that memory, moving larger entries up one position
// at a time, then a coalescing pass; worst case grows with count squared.
// Configuration writes go through i_cfg_we/i_cfg_index/i_cfg_data while
// idle, a rule for the user that the block does not enforce; writing the
// pool start or length reloads the bump pointer. Reset clears the registers,
// the bump region and the list count; no clearing pass is needed. The result
// sits in an output register, so a new request is taken while it waits; a
// following result is held until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module pool_allocator_free_list_unit #(
    parameter int FREE_SLOTS = plfl_pkg::FREE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_align,
    input  logic [31:0] i_free_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_address,
    output logic [31:0] o_granted_offset,
    output logic [31:0] o_granted_size
);

    localparam int AW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);

    plfl_pkg::t_state r_state, n_state;
    plfl_pkg::t_act   act;

    logic [1:0]  r_op, n_op;
    logic [31:0] r_req, n_req;
    logic [31:0] r_al, n_al;
    logic [31:0] r_foff, n_foff;
    logic [31:0] r_size, n_size;
    logic [2:0]  r_step, n_step;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_bump_off, n_bump_off;
    logic [31:0] r_bump_rem, n_bump_rem;
    logic [63:0] r_base, n_base;
    logic [1:0]  r_policy, n_policy;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_bidx, n_bidx;
    plfl_pkg::t_chunk r_key, n_key;
    logic        r_have, n_have;
    logic        r_pend, n_pend;
    logic        r_found, n_found;
    logic        r_first, n_first;
    logic [31:0] r_bsize, n_bsize;
    logic [31:0] r_boff, n_boff;
    logic [1:0]  r_res_status, n_res_status;
    logic [31:0] r_res_off, n_res_off;
    logic        r_res_grant, n_res_grant;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status, n_out_status;
    logic [63:0] r_out_addr, n_out_addr;
    logic [31:0] r_out_off, n_out_off;
    logic [31:0] r_out_size, n_out_size;

    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    plfl_pkg::t_chunk mem_wdata, mem_rdata;

    logic        div_start, div_done;
    logic [31:0] div_rem, div_dsr;
    logic [32:0] round_t;
    logic [32:0] end_sum, size_sum;
    logic [1:0]  pol;
    logic [CW-1:0] cnt_last, i_prev, j_back2;

    assign div_dsr   = (r_al == 32'd0) ? 32'd1 : r_al;
    assign div_start = (r_state == plfl_pkg::S_DECODE) && (r_op == plfl_pkg::OP_ALLOC);
    assign round_t   = (div_rem == 32'd0) ? {1'b0, r_req}
                     : {1'b0, r_req} + {1'b0, div_dsr} - {1'b0, div_rem};
    assign end_sum   = {1'b0, r_key.offset} + {1'b0, r_key.size};
    assign size_sum  = {1'b0, r_key.size} + {1'b0, mem_rdata.size};
    assign pol       = (r_policy == 2'd3) ? plfl_pkg::POL_BUMP : r_policy;
    assign cnt_last  = r_count - CW'(1);
    assign i_prev    = r_i - CW'(1);
    assign j_back2   = r_j - CW'(2);

    plfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_req),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    plfl_mem #(
        .DEPTH (FREE_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        unique case (pol)
            plfl_pkg::POL_BEST: begin
                case (r_step)
                    3'd0:    act = plfl_pkg::ACT_BEST;
                    3'd1:    act = plfl_pkg::ACT_BUMP;
                    3'd2:    act = plfl_pkg::ACT_DEFRAG;
                    3'd3:    act = plfl_pkg::ACT_BEST;
                    default: act = plfl_pkg::ACT_FAIL;
                endcase
            end
            plfl_pkg::POL_FIRST: begin
                case (r_step)
                    3'd0:    act = plfl_pkg::ACT_FIRST;
                    3'd1:    act = plfl_pkg::ACT_BUMP;
                    default: act = plfl_pkg::ACT_FAIL;
                endcase
            end
            default: begin
                case (r_step)
                    3'd0:    act = plfl_pkg::ACT_BUMP;
                    3'd1:    act = plfl_pkg::ACT_BEST;
                    default: act = plfl_pkg::ACT_FAIL;
                endcase
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_req        = r_req;
        n_al         = r_al;
        n_foff       = r_foff;
        n_size       = r_size;
        n_step       = r_step;
        n_count      = r_count;
        n_bump_off   = r_bump_off;
        n_bump_rem   = r_bump_rem;
        n_base       = r_base;
        n_policy     = r_policy;
        n_i          = r_i;
        n_j          = r_j;
        n_n          = r_n;
        n_pidx       = r_pidx;
        n_bidx       = r_bidx;
        n_key        = r_key;
        n_have       = r_have;
        n_pend       = r_pend;
        n_found      = r_found;
        n_first      = r_first;
        n_bsize      = r_bsize;
        n_boff       = r_boff;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_grant  = r_res_grant;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_off    = r_out_off;
        n_out_size   = r_out_size;
        n_out_valid  = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                plfl_pkg::CFG_BASE:   n_base     = i_cfg_data;
                plfl_pkg::CFG_START:  n_bump_off = i_cfg_data[31:0];
                plfl_pkg::CFG_LENGTH: n_bump_rem = i_cfg_data[31:0];
                plfl_pkg::CFG_POLICY: n_policy   = i_cfg_data[1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            plfl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_req   = i_request_size;
                    n_al    = i_align;
                    n_foff  = i_free_offset;
                    n_state = plfl_pkg::S_DECODE;
                end
            end
            plfl_pkg::S_DECODE: begin
                n_res_status = plfl_pkg::ST_OK;
                n_res_grant  = 1'b0;
                n_res_off    = '0;
                n_step       = '0;
                case (r_op)
                    plfl_pkg::OP_ALLOC: n_state = plfl_pkg::S_DIV;
                    plfl_pkg::OP_FREE: begin
                        if (r_count >= CW'(FREE_SLOTS)) begin
                            n_res_status = plfl_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = '{offset: r_foff, size: r_req};
                            n_count   = r_count + CW'(1);
                        end
                        n_state = plfl_pkg::S_DONE;
                    end
                    plfl_pkg::OP_DEFRAG: begin
                        n_i     = CW'(1);
                        n_state = plfl_pkg::S_SORT_NEXT;
                    end
                    default: n_state = plfl_pkg::S_DONE;
                endcase
            end
            plfl_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = plfl_pkg::S_ROUND;
                end
            end
            plfl_pkg::S_ROUND: begin
                if (round_t[32]) begin
                    n_res_status = plfl_pkg::ST_NOMEM;
                    n_state      = plfl_pkg::S_DONE;
                end else begin
                    n_size  = round_t[31:0];
                    n_state = plfl_pkg::S_DISPATCH;
                end
            end
            plfl_pkg::S_DISPATCH: begin
                unique case (act)
                    plfl_pkg::ACT_BUMP: begin
                        if (r_bump_rem >= r_size) begin
                            n_res_grant = 1'b1;
                            n_res_off   = r_bump_off;
                            n_bump_off  = r_bump_off + r_size;
                            n_bump_rem  = r_bump_rem - r_size;
                            n_state     = plfl_pkg::S_DONE;
                        end else begin
                            n_step = r_step + 3'd1;
                        end
                    end
                    plfl_pkg::ACT_BEST, plfl_pkg::ACT_FIRST: begin
                        n_first = (act == plfl_pkg::ACT_FIRST);
                        n_i     = '0;
                        n_pend  = 1'b0;
                        n_found = 1'b0;
                        n_state = plfl_pkg::S_SCAN;
                    end
                    plfl_pkg::ACT_DEFRAG: begin
                        n_i     = CW'(1);
                        n_state = plfl_pkg::S_SORT_NEXT;
                    end
                    default: begin
                        n_res_status = plfl_pkg::ST_NOMEM;
                        n_state      = plfl_pkg::S_DONE;
                    end
                endcase
            end
            plfl_pkg::S_SCAN: begin
                if (r_i < r_count) begin
                    mem_raddr = r_i[AW-1:0];
                    n_i       = r_i + CW'(1);
                    n_pend    = 1'b1;
                    n_pidx    = r_i;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && mem_rdata.size >= r_size && (!r_found ||
                    (!r_first && mem_rdata.size < r_bsize))) begin
                    n_found = 1'b1;
                    n_bidx  = r_pidx;
                    n_bsize = mem_rdata.size;
                    n_boff  = mem_rdata.offset;
                end
                if (!(r_i < r_count) && !r_pend) begin
                    if (r_found) begin
                        n_state = plfl_pkg::S_TAKE_RD;
                    end else begin
                        n_step  = r_step + 3'd1;
                        n_state = plfl_pkg::S_DISPATCH;
                    end
                end
            end
            plfl_pkg::S_TAKE_RD: begin
                mem_raddr = cnt_last[AW-1:0];
                n_state   = plfl_pkg::S_TAKE_WR;
            end
            plfl_pkg::S_TAKE_WR: begin
                mem_we      = 1'b1;
                mem_waddr   = r_bidx[AW-1:0];
                mem_wdata   = mem_rdata;
                n_count     = r_count - CW'(1);
                n_res_grant = 1'b1;
                n_res_off   = r_boff;
                n_state     = plfl_pkg::S_DONE;
            end
            plfl_pkg::S_SORT_NEXT: begin
                if (r_i < r_count) begin
                    mem_raddr = r_i[AW-1:0];
                    n_state   = plfl_pkg::S_SORT_GETI;
                end else begin
                    n_i     = '0;
                    n_n     = '0;
                    n_have  = 1'b0;
                    n_state = plfl_pkg::S_MERGE_NEXT;
                end
            end
            plfl_pkg::S_SORT_GETI: begin
                n_key     = mem_rdata;
                n_j       = r_i;
                mem_raddr = i_prev[AW-1:0];
                n_state   = plfl_pkg::S_SORT_CMP;
            end
            plfl_pkg::S_SORT_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata.offset > r_key.offset) begin
                    mem_waddr = r_j[AW-1:0];
                    mem_wdata = mem_rdata;
                    n_j       = r_j - CW'(1);
                    if (r_j != CW'(1)) begin
                        mem_raddr = j_back2[AW-1:0];
                    end else begin
                        n_state = plfl_pkg::S_SORT_PUT;
                    end
                end else begin
                    mem_waddr = r_j[AW-1:0];
                    mem_wdata = r_key;
                    n_i       = r_i + CW'(1);
                    n_state   = plfl_pkg::S_SORT_NEXT;
                end
            end
            plfl_pkg::S_SORT_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[AW-1:0];
                mem_wdata = r_key;
                n_i       = r_i + CW'(1);
                n_state   = plfl_pkg::S_SORT_NEXT;
            end
            plfl_pkg::S_MERGE_NEXT: begin
                if (r_i < r_count) begin
                    mem_raddr = r_i[AW-1:0];
                    n_state   = plfl_pkg::S_MERGE_GET;
                end else begin
                    n_state = plfl_pkg::S_MERGE_END;
                end
            end
            plfl_pkg::S_MERGE_GET: begin
                n_i     = r_i + CW'(1);
                n_state = plfl_pkg::S_MERGE_NEXT;
                if (mem_rdata.size != 32'd0) begin
                    if (r_have && end_sum == {1'b0, mem_rdata.offset} && !size_sum[32]) begin
                        n_key.size = size_sum[31:0];
                    end else begin
                        if (r_have) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_n[AW-1:0];
                            mem_wdata = r_key;
                            n_n       = r_n + CW'(1);
                        end
                        n_key  = mem_rdata;
                        n_have = 1'b1;
                    end
                end
            end
            plfl_pkg::S_MERGE_END: begin
                if (r_have) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_n[AW-1:0];
                    mem_wdata = r_key;
                end
                n_count = r_n + CW'(r_have);
                if (r_op == plfl_pkg::OP_DEFRAG) begin
                    n_state = plfl_pkg::S_DONE;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = plfl_pkg::S_DISPATCH;
                end
            end
            plfl_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_grant ? r_base + {32'd0, r_res_off} : 64'd0;
                    n_out_off    = r_res_grant ? r_res_off : 32'd0;
                    n_out_size   = r_res_grant ? r_size : 32'd0;
                    n_state      = plfl_pkg::S_IDLE;
                end
            end
            default: n_state = plfl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_req        <= n_req;
        r_al         <= n_al;
        r_foff       <= n_foff;
        r_size       <= n_size;
        r_step       <= n_step;
        r_i          <= n_i;
        r_j          <= n_j;
        r_n          <= n_n;
        r_pidx       <= n_pidx;
        r_bidx       <= n_bidx;
        r_key        <= n_key;
        r_have       <= n_have;
        r_pend       <= n_pend;
        r_found      <= n_found;
        r_first      <= n_first;
        r_bsize      <= n_bsize;
        r_boff       <= n_boff;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_grant  <= n_res_grant;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_off    <= n_out_off;
        r_out_size   <= n_out_size;
        if (!i_rst_n) begin
            r_state     <= plfl_pkg::S_IDLE;
            r_count     <= '0;
            r_bump_off  <= '0;
            r_bump_rem  <= '0;
            r_base      <= '0;
            r_policy    <= plfl_pkg::POL_BUMP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bump_off  <= n_bump_off;
            r_bump_rem  <= n_bump_rem;
            r_base      <= n_base;
            r_policy    <= n_policy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready       = (r_state == plfl_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_address        = r_out_addr;
    assign o_granted_offset = r_out_off;
    assign o_granted_size   = r_out_size;

endmodule

@@ rtl/plfl_checker.sv @@
// ----------------------------------------------------------------------------
// plfl_checker
// Port-level checks of the pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module plfl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [63:0] o_address,
    input logic [31:0] o_granted_offset,
    input logic [31:0] o_granted_size
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != plfl_pkg::ST_OK |->
        o_address == 64'd0 && o_granted_offset == 32'd0 && o_granted_size == 32'd0)
        else $error("failed item carries grant fields");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while previous one in work");

    a_no_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted_size == 32'd0 |-> o_granted_offset == 32'd0 ||
        o_status == plfl_pkg::ST_OK)
        else $error("offset without grant on failure");

endmodule

bind pool_allocator_free_list_unit plfl_checker u_plfl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_address        (o_address),
    .o_granted_offset (o_granted_offset),
    .o_granted_size   (o_granted_size)
);
